/* rtl/core/lcbt_pkg.sv */
// Shared types, constants and helpers for the link circuit breaker table.
`default_nettype none

package lcbt_pkg;

  localparam int DEF_LOCAL_PORTS  = 16;
  localparam int DEF_REMOTE_PORTS = 16;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ERR_THRESHOLD = 3'd0,
    CFG_ERR_WINDOW    = 3'd1,
    CFG_INIT_COOLDOWN = 3'd2,
    CFG_PROBE_IVAL    = 3'd3,
    CFG_MAX_COOLDOWN  = 3'd4
  } cfg_idx_e;

  localparam logic [7:0]  RST_ERR_THRESHOLD = 8'd3;
  localparam logic [23:0] RST_ERR_WINDOW    = 24'd10;
  localparam logic [23:0] RST_INIT_COOLDOWN = 24'd30;
  localparam logic [23:0] RST_PROBE_IVAL    = 24'd5;
  localparam logic [23:0] RST_MAX_COOLDOWN  = 24'd300;

  typedef enum logic [1:0] {
    OP_QUERY   = 2'd0,
    OP_FAILURE = 2'd1,
    OP_SUCCESS = 2'd2
  } op_e;

  localparam logic [1:0] MODE_CLOSED = 2'd0;
  localparam logic [1:0] MODE_OPEN   = 2'd1;
  localparam logic [1:0] MODE_TRIAL  = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  local_port;
    logic [3:0]  remote_port;
    logic [31:0] now_time;
  } cmd_t;

  typedef struct packed {
    logic        pair_known;
    logic        admitted;
    logic [1:0]  pair_mode;
    logic [23:0] current_cooldown;
    logic        remap_needed;
  } res_t;

  // One health record per port pair; all zero is the reset state.
  typedef struct packed {
    logic        paused;
    logic        trial;
    logic [7:0]  fail_cnt;
    logic [23:0] pause_len;
    logic [31:0] resume_at;
    logic [31:0] last_fail_at;
    logic [31:0] last_probe_at;
  } rec_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic exec;
    logic clear;
  } ctrl_cmd_t;

  function automatic int addr_w(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/lcbt_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none

module lcbt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/lcbt_ctrl.sv */
// Controller: clearing sweep after reset and per-item sequencing.
`default_nettype none

module lcbt_ctrl #(
  parameter int LOCAL_PORTS  = lcbt_pkg::DEF_LOCAL_PORTS,
  parameter int REMOTE_PORTS = lcbt_pkg::DEF_REMOTE_PORTS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  output lcbt_pkg::ctrl_cmd_t      ctl_o,
  output logic [lcbt_pkg::addr_w(LOCAL_PORTS*REMOTE_PORTS)-1:0] clr_addr_o
);

  import lcbt_pkg::*;

  localparam int Pairs = LOCAL_PORTS * REMOTE_PORTS;
  localparam int AddrW = addr_w(Pairs);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Pairs - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e           state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == LastAddr) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  assign busy       = (state_q != ST_IDLE);
  assign ctl_o.load  = start && (state_q == ST_IDLE);
  assign ctl_o.exec  = (state_q == ST_EXEC);
  assign ctl_o.clear = (state_q == ST_CLEAR);
  assign clr_addr_o  = clr_q;

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_o.load, ctl_o.exec, ctl_o.clear}))
    else $error("controller issued overlapping commands");

endmodule

`default_nettype wire

/* rtl/core/lcbt_dpath.sv */
// Datapath: config registers, record table and breaker update logic.
`default_nettype none

module lcbt_dpath #(
  parameter int LOCAL_PORTS  = lcbt_pkg::DEF_LOCAL_PORTS,
  parameter int REMOTE_PORTS = lcbt_pkg::DEF_REMOTE_PORTS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  lcbt_pkg::cmd_t                         cmd_i,
  input  lcbt_pkg::ctrl_cmd_t                    ctl_i,
  input  logic [lcbt_pkg::addr_w(LOCAL_PORTS*REMOTE_PORTS)-1:0] clr_addr_i,
  input  logic                                   cfg_we_i,
  input  logic [lcbt_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [lcbt_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  output lcbt_pkg::res_t                         res_o,
  output logic                                   done_o
);

  import lcbt_pkg::*;

  localparam int Pairs = LOCAL_PORTS * REMOTE_PORTS;
  localparam int AddrW = addr_w(Pairs);
  localparam int RecW  = $bits(rec_t);

  logic [7:0]  thr_q;
  logic [23:0] win_q, init_q, pint_q, maxc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= RST_ERR_THRESHOLD;
      win_q  <= RST_ERR_WINDOW;
      init_q <= RST_INIT_COOLDOWN;
      pint_q <= RST_PROBE_IVAL;
      maxc_q <= RST_MAX_COOLDOWN;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ERR_THRESHOLD: thr_q  <= cfg_data_i[7:0];
        CFG_ERR_WINDOW:    win_q  <= cfg_data_i;
        CFG_INIT_COOLDOWN: init_q <= cfg_data_i;
        CFG_PROBE_IVAL:    pint_q <= cfg_data_i;
        CFG_MAX_COOLDOWN:  maxc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Table index of the incoming item.
  logic [31:0]      idx_full;
  logic             known_in;
  logic [AddrW-1:0] idx_in;

  assign idx_full = 32'(cmd_i.local_port) * 32'(REMOTE_PORTS) + 32'(cmd_i.remote_port);
  assign idx_in   = idx_full[AddrW-1:0];
  assign known_in = (32'(cmd_i.local_port) < 32'(LOCAL_PORTS)) &&
                    (32'(cmd_i.remote_port) < 32'(REMOTE_PORTS));

  cmd_t             cmd_q;
  logic             known_q;
  logic [AddrW-1:0] idx_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q   <= cmd_i;
      known_q <= known_in;
      idx_q   <= idx_in;
    end
  end

  logic [RecW-1:0]  rdata;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [RecW-1:0]  ram_wdata;
  rec_t             rec, nxt;
  logic             adm, remap;

  lcbt_ram #(
    .Width (RecW),
    .Depth (Pairs)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ctl_i.load),
    .raddr_i (idx_in),
    .rdata_o (rdata)
  );

  assign rec = rec_t'(rdata);

  always_comb begin
    logic [31:0] now;
    logic [31:0] d_probe, d_res, d_fail;
    logic        probe_ok, beyond;
    logic [24:0] dbl_raw;
    logic [23:0] dbl, fresh_len;
    logic [7:0]  cnt1;

    now      = cmd_q.now_time;
    nxt      = rec;
    adm      = 1'b0;
    remap    = 1'b0;
    d_probe  = now - rec.last_probe_at;
    d_res    = now - rec.resume_at;
    d_fail   = now - rec.last_fail_at;
    probe_ok = (pint_q != '0) && !d_probe[31] && (d_probe >= {8'd0, pint_q});
    beyond   = !d_fail[31] && (d_fail > {8'd0, win_q});
    dbl_raw  = {rec.pause_len, 1'b0};
    dbl      = (dbl_raw > {1'b0, maxc_q}) ? maxc_q : dbl_raw[23:0];
    fresh_len = (rec.pause_len == '0) ? init_q : dbl;
    if (rec.fail_cnt == '0 || beyond) begin
      cnt1 = 8'd1;
    end else if (rec.fail_cnt != 8'hFF) begin
      cnt1 = rec.fail_cnt + 8'd1;
    end else begin
      cnt1 = rec.fail_cnt;
    end

    unique case (cmd_q.op)
      OP_QUERY: begin
        if (!rec.paused && !rec.trial) begin
          adm = 1'b1;
        end else if (rec.trial || d_res[31]) begin
          // Throttled probe while paused or on trial.
          if (probe_ok) begin
            nxt.last_probe_at = now;
            adm = 1'b1;
          end
        end else begin
          // Cooldown ran out: admit the half-open trial.
          nxt.trial         = 1'b1;
          nxt.fail_cnt      = '0;
          nxt.last_probe_at = now;
          adm = 1'b1;
        end
      end
      OP_FAILURE: begin
        nxt.last_fail_at = now;
        nxt.fail_cnt     = cnt1;
        if (rec.trial) begin
          nxt.trial         = 1'b0;
          nxt.pause_len     = dbl;
          nxt.fail_cnt      = '0;
          nxt.resume_at     = now + {8'd0, dbl};
          nxt.last_probe_at = now;
          remap = 1'b1;
        end else if (cnt1 >= thr_q && !rec.paused) begin
          nxt.pause_len     = fresh_len;
          nxt.paused        = 1'b1;
          nxt.resume_at     = now + {8'd0, fresh_len};
          nxt.last_probe_at = now;
          remap = 1'b1;
        end
      end
      OP_SUCCESS: begin
        if (rec.paused || rec.trial || rec.fail_cnt != '0 || rec.pause_len != '0) begin
          nxt.fail_cnt      = '0;
          nxt.resume_at     = '0;
          nxt.pause_len     = '0;
          nxt.trial         = 1'b0;
          nxt.paused        = 1'b0;
          nxt.last_probe_at = '0;
          remap = rec.paused || rec.trial;
        end
      end
      default: ;
    endcase
  end

  assign ram_we    = ctl_i.clear || (ctl_i.exec && known_q);
  assign ram_waddr = ctl_i.clear ? clr_addr_i : idx_q;
  assign ram_wdata = ctl_i.clear ? '0 : RecW'(nxt);

  res_t res_d, res_q;
  logic done_q;

  always_comb begin
    res_d = '0;
    if (known_q) begin
      res_d.pair_known       = 1'b1;
      res_d.admitted         = adm;
      res_d.pair_mode        = nxt.trial ? MODE_TRIAL :
                               (nxt.paused ? MODE_OPEN : MODE_CLOSED);
      res_d.current_cooldown = nxt.pause_len;
      res_d.remap_needed     = remap;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.exec) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_i.exec;
    end
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

/* rtl/core/link_circuit_breaker_table_unit.sv */
// Top level of the per-pair link circuit breaker table.
//
//   channel   signals                                      direction
//   command   start, busy, cmd_i                           in (busy out)
//   result    done_o, res_o                                out
//   config    cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i   in (ready out)
//
// After reset the record table is swept to zero, one entry a cycle; busy stays
// high and no item is taken. Config writes are taken only while busy is low
// and no item is started. Each item runs as the record read from the table
// RAM, then the update and write back. done_o pulses in the cycle after the
// second step, and a new item may be started in that same cycle. Results
// cannot be stalled.
`default_nettype none

module link_circuit_breaker_table_unit #(
  parameter int LOCAL_PORTS  = lcbt_pkg::DEF_LOCAL_PORTS,
  parameter int REMOTE_PORTS = lcbt_pkg::DEF_REMOTE_PORTS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  lcbt_pkg::cmd_t                  cmd_i,
  output logic                            done_o,
  output lcbt_pkg::res_t                  res_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lcbt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lcbt_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import lcbt_pkg::*;

  localparam int AddrW = addr_w(LOCAL_PORTS * REMOTE_PORTS);

  ctrl_cmd_t        ctl;
  logic [AddrW-1:0] clr_addr;

  // Hold config writes off while an item is in flight or being started.
  assign cfg_ready_o = !busy && !start;

  lcbt_ctrl #(
    .LOCAL_PORTS  (LOCAL_PORTS),
    .REMOTE_PORTS (REMOTE_PORTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .ctl_o      (ctl),
    .clr_addr_o (clr_addr)
  );

  lcbt_dpath #(
    .LOCAL_PORTS  (LOCAL_PORTS),
    .REMOTE_PORTS (REMOTE_PORTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .ctl_i       (ctl),
    .clr_addr_i  (clr_addr),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_o       (res_o),
    .done_o      (done_o)
  );

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("accepted item produced no result");

  a_no_double: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("results issued in consecutive cycles");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> $past(busy))
    else $error("result without a preceding busy cycle");

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the link circuit breaker table: directed script, then random items.
module testbench;
  import lcbt_pkg::*;

  localparam int LOCAL_PORTS  = DEF_LOCAL_PORTS;
  localparam int REMOTE_PORTS = DEF_REMOTE_PORTS;
  localparam int PAIRS        = LOCAL_PORTS * REMOTE_PORTS;
  // Op code with no meaning; the block must leave the record alone.
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  cmd_t                  cmd_i       = '0;
  logic                  done_o;
  res_t                  res_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  link_circuit_breaker_table_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Breaker settings and per-pair health records as the block should hold them.
  logic [7:0]  trip_count  = RST_ERR_THRESHOLD;
  logic [23:0] fail_window = RST_ERR_WINDOW;
  logic [23:0] first_pause = RST_INIT_COOLDOWN;
  logic [23:0] probe_gap   = RST_PROBE_IVAL;
  logic [23:0] pause_cap   = RST_MAX_COOLDOWN;
  rec_t        breaker [PAIRS];

  res_t        awaited_results [$];
  int          errors   = 0;
  int          n_items  = 0;
  int          n_phases = 0;
  int          n_pauses = 0;
  int          n_trials = 0;
  logic [31:0] wall;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  lport;
    logic [3:0]  rport;
    logic [31:0] stamp;
    logic        typed;
    logic        adm;
    logic [1:0]  mode;
    logic [23:0] cool;
    logic        remap;
  } script_row_t;

  // Reset settings: threshold 3, window 10, cooldown 30, probes every 5, cap 300.
  script_row_t script [25] = '{
    '{OP_QUERY,   4'd0,  4'd0,  32'd0,          1'b1, 1'b1, MODE_CLOSED, 24'd0,  1'b0},
    '{OP_SPARE,   4'd15, 4'd15, 32'hFFFF_FFFF,  1'b1, 1'b0, MODE_CLOSED, 24'd0,  1'b0},
    '{OP_SUCCESS, 4'd15, 4'd15, 32'd0,          1'b1, 1'b0, MODE_CLOSED, 24'd0,  1'b0},
    '{OP_FAILURE, 4'd0,  4'd0,  32'd100,        1'b1, 1'b0, MODE_CLOSED, 24'd0,  1'b0},
    '{OP_FAILURE, 4'd0,  4'd0,  32'd105,        1'b1, 1'b0, MODE_CLOSED, 24'd0,  1'b0},
    '{OP_FAILURE, 4'd0,  4'd0,  32'd110,        1'b1, 1'b0, MODE_OPEN,   24'd30, 1'b1},
    '{OP_QUERY,   4'd0,  4'd0,  32'd112,        1'b0, 1'b0, MODE_CLOSED, 24'd0,  1'b0},
    '{OP_QUERY,   4'd0,  4'd0,  32'd115,        1'b0, 1'b0, MODE_CLOSED, 24'd0,  1'b0},
    '{OP_SPARE,   4'd0,  4'd0,  32'd116,        1'b0, 1'b0, MODE_CLOSED, 24'd0,  1'b0},
    '{OP_QUERY,   4'd0,  4'd0,  32'd140,        1'b0, 1'b0, MODE_CLOSED, 24'd0,  1'b0},
    '{OP_QUERY,   4'd0,  4'd0,  32'd141,        1'b0, 1'b0, MODE_CLOSED, 24'd0,  1'b0},
    '{OP_FAILURE, 4'd0,  4'd0,  32'd142,        1'b0, 1'b0, MODE_CLOSED, 24'd0,  1'b0},
    '{OP_QUERY,   4'd0,  4'd0,  32'd202,        1'b0, 1'b0, MODE_CLOSED, 24'd0,  1'b0},
    '{OP_SUCCESS, 4'd0,  4'd0,  32'd203,        1'b1, 1'b0, MODE_CLOSED, 24'd0,  1'b1},
    '{OP_FAILURE, 4'd15, 4'd15, 32'hFFFF_FFF0,  1'b0, 1'b0, MODE_CLOSED, 24'd0,  1'b0},
    '{OP_FAILURE, 4'd15, 4'd15, 32'hFFFF_FFF8,  1'b0, 1'b0, MODE_CLOSED, 24'd0,  1'b0},
    '{OP_FAILURE, 4'd15, 4'd15, 32'd2,          1'b0, 1'b0, MODE_CLOSED, 24'd0,  1'b0},
    '{OP_QUERY,   4'd15, 4'd15, 32'hFFFF_FFFF,  1'b0, 1'b0, MODE_CLOSED, 24'd0,  1'b0},
    '{OP_QUERY,   4'd15, 4'd15, 32'h8000_0000,  1'b0, 1'b0, MODE_CLOSED, 24'd0,  1'b0},
    '{OP_FAILURE, 4'd15, 4'd15, 32'h8000_0001,  1'b0, 1'b0, MODE_CLOSED, 24'd0,  1'b0},
    '{OP_FAILURE, 4'd1,  4'd2,  32'd10,         1'b0, 1'b0, MODE_CLOSED, 24'd0,  1'b0},
    '{OP_FAILURE, 4'd1,  4'd2,  32'd21,         1'b0, 1'b0, MODE_CLOSED, 24'd0,  1'b0},
    '{OP_FAILURE, 4'd15, 4'd0,  32'h5555_5555,  1'b0, 1'b0, MODE_CLOSED, 24'd0,  1'b0},
    '{OP_QUERY,   4'd0,  4'd15, 32'hAAAA_AAAA,  1'b0, 1'b0, MODE_CLOSED, 24'd0,  1'b0},
    '{OP_SUCCESS, 4'd10, 4'd5,  32'd0,          1'b0, 1'b0, MODE_CLOSED, 24'd0,  1'b0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Time since t reached (or, when strict, passed) lim, read as a signed difference.
  function automatic logic aged(input logic [31:0] now, input logic [31:0] t,
                                input logic [23:0] lim, input logic strict);
    logic [31:0] d;
    d = now - t;
    return !d[31] && (strict ? d > {8'd0, lim} : d >= {8'd0, lim});
  endfunction

  function automatic logic [23:0] backoff(input logic [23:0] len);
    logic [24:0] v;
    v = {len, 1'b0};
    if (v > {1'b0, pause_cap}) v = {1'b0, pause_cap};
    return v[23:0];
  endfunction

  function automatic res_t breaker_step(input cmd_t c);
    res_t        r;
    rec_t        h;
    int unsigned k;
    logic [31:0] now;
    logic [31:0] d_res;
    logic        was_active;
    r = '0;
    if (c.local_port >= LOCAL_PORTS || c.remote_port >= REMOTE_PORTS) return r;
    k = c.local_port * REMOTE_PORTS + c.remote_port;
    h = breaker[k];
    now = c.now_time;
    d_res = now - h.resume_at;
    case (c.op)
      OP_QUERY: begin
        if (!h.paused && !h.trial) begin
          r.admitted = 1'b1;
        end else if (h.trial || d_res[31]) begin
          // still cooling down (or trial running): only throttled probes pass
          if (probe_gap != '0 && aged(now, h.last_probe_at, probe_gap, 1'b0)) begin
            h.last_probe_at = now;
            r.admitted = 1'b1;
          end
        end else begin
          h.trial         = 1'b1;
          h.fail_cnt      = '0;
          h.last_probe_at = now;
          r.admitted      = 1'b1;
        end
      end
      OP_FAILURE: begin
        if (h.fail_cnt == '0 || aged(now, h.last_fail_at, fail_window, 1'b1))
          h.fail_cnt = 8'd1;
        else if (h.fail_cnt != 8'hFF)
          h.fail_cnt = h.fail_cnt + 8'd1;
        h.last_fail_at = now;
        if (h.trial) begin
          h.trial          = 1'b0;
          h.pause_len      = backoff(h.pause_len);
          h.fail_cnt       = '0;
          h.resume_at      = now + {8'd0, h.pause_len};
          h.last_probe_at  = now;
          r.remap_needed   = 1'b1;
        end else if (h.fail_cnt >= trip_count && !h.paused) begin
          h.pause_len      = (h.pause_len == '0) ? first_pause : backoff(h.pause_len);
          h.paused         = 1'b1;
          h.resume_at      = now + {8'd0, h.pause_len};
          h.last_probe_at  = now;
          r.remap_needed   = 1'b1;
        end
      end
      OP_SUCCESS: begin
        was_active = h.paused || h.trial;
        if (was_active || h.fail_cnt != '0 || h.pause_len != '0) begin
          h.fail_cnt      = '0;
          h.resume_at     = '0;
          h.pause_len     = '0;
          h.trial         = 1'b0;
          h.paused        = 1'b0;
          h.last_probe_at = '0;
          r.remap_needed  = was_active;
        end
      end
      default: ;
    endcase
    breaker[k] = h;
    r.pair_known       = 1'b1;
    r.pair_mode        = h.trial ? MODE_TRIAL : (h.paused ? MODE_OPEN : MODE_CLOSED);
    r.current_cooldown = h.pause_len;
    return r;
  endfunction

  // Present one item and hold it until the block takes it.
  task automatic issue(input cmd_t c, input logic typed, input res_t want);
    res_t r;
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    r = breaker_step(c);
    awaited_results = {awaited_results, (typed ? want : r)};
    n_items++;
    if (r.remap_needed && r.pair_mode == MODE_OPEN) n_pauses++;
    if (r.admitted && r.pair_mode == MODE_TRIAL) n_trials++;
  endtask

  task automatic hold_off(input int unsigned n);
    cmd_t        junk;
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    junk  = noise[$bits(cmd_t)-1:0];
    if (n != 0) begin
      start <= 1'b0;
      cmd_i <= junk;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Write all five registers back to back.
  task automatic load_settings(input logic [23:0] t, input logic [23:0] w,
                               input logic [23:0] ic, input logic [23:0] pi,
                               input logic [23:0] mx);
    logic [23:0] vals [5];
    vals = '{t, w, ic, pi, mx};
    for (int i = 0; i < 5; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= cfg_idx_e'(i);
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (cfg_idx_e'(i))
        CFG_ERR_THRESHOLD: trip_count  = vals[i][7:0];
        CFG_ERR_WINDOW:    fail_window = vals[i];
        CFG_INIT_COOLDOWN: first_pause = vals[i];
        CFG_PROBE_IVAL:    probe_gap   = vals[i];
        CFG_MAX_COOLDOWN:  pause_cap   = vals[i];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // One register setting, then random traffic mostly on a few hot pairs.
  task automatic run_phase(input logic [23:0] t, input logic [23:0] w,
                           input logic [23:0] ic, input logic [23:0] pi,
                           input logic [23:0] mx,
                           input int unsigned near, input int unsigned far,
                           input int unsigned far_pct, input int unsigned stray_pct,
                           input int unsigned n, input int unsigned hot,
                           input int unsigned fail_pct, input int unsigned ok_pct);
    cmd_t        c;
    logic [7:0]  pairs [4];
    logic [7:0]  p;
    int unsigned roll;
    int unsigned gap;
    logic        quiet;
    quiet = 1'b0;
    hold_off(1);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    load_settings(t, w, ic, pi, mx);
    foreach (pairs[j]) pairs[j] = 8'($urandom);
    wall = $urandom;
    n_phases++;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
      p = ($urandom_range(0, 99) < 85) ? pairs[$urandom_range(0, hot - 1)] : 8'($urandom);
      c.local_port  = p[7:4];
      c.remote_port = p[3:0];
      roll = $urandom_range(0, 99);
      if (roll < fail_pct)                   c.op = OP_FAILURE;
      else if (roll < fail_pct + ok_pct)     c.op = OP_SUCCESS;
      else if (roll < fail_pct + ok_pct + 2) c.op = OP_SPARE;
      else                                   c.op = OP_QUERY;
      roll = $urandom_range(0, 99);
      if (roll < stray_pct) begin
        c.now_time = $urandom;
      end else begin
        wall = wall + ((roll < stray_pct + far_pct) ? $urandom_range(0, far)
                                                     : $urandom_range(0, near));
        c.now_time = wall;
      end
      issue(c, 1'b0, '0);
      roll = $urandom_range(0, 99);
      if (quiet || roll < 50) gap = 0;
      else if (roll < 85)     gap = $urandom_range(1, 3);
      else                    gap = $urandom_range(5, 40);
      hold_off(gap);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && done_o) begin
      if (awaited_results.size() == 0) begin
        $error("result with no item outstanding: %p", res_o);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (res_o.pair_known !== want.pair_known) begin
          $error("pair_known: expected %0d, got %0d", want.pair_known, res_o.pair_known);
          errors++;
        end
        if (res_o.admitted !== want.admitted) begin
          $error("admitted: expected %0d, got %0d", want.admitted, res_o.admitted);
          errors++;
        end
        if (res_o.pair_mode !== want.pair_mode) begin
          $error("pair_mode: expected %0d, got %0d", want.pair_mode, res_o.pair_mode);
          errors++;
        end
        if (res_o.current_cooldown !== want.current_cooldown) begin
          $error("current_cooldown: expected %0d, got %0d",
                 want.current_cooldown, res_o.current_cooldown);
          errors++;
        end
        if (res_o.remap_needed !== want.remap_needed) begin
          $error("remap_needed: expected %0d, got %0d", want.remap_needed, res_o.remap_needed);
          errors++;
        end
      end
    end
  end

  initial begin
    cmd_t c;
    res_t want;
    foreach (breaker[i]) breaker[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed script, back to back, under reset settings.
    foreach (script[i]) begin
      c.op               = script[i].op;
      c.local_port       = script[i].lport;
      c.remote_port      = script[i].rport;
      c.now_time         = script[i].stamp;
      want.pair_known    = 1'b1;
      want.admitted      = script[i].adm;
      want.pair_mode     = script[i].mode;
      want.current_cooldown = script[i].cool;
      want.remap_needed  = script[i].remap;
      issue(c, script[i].typed, want);
    end

    run_phase(24'(RST_ERR_THRESHOLD), RST_ERR_WINDOW, RST_INIT_COOLDOWN, RST_PROBE_IVAL,
              RST_MAX_COOLDOWN, 12, 60, 25, 3, 100, 4, 45, 8);
    run_phase(24'd1, 24'd0, 24'd0, 24'd0, 24'd0, 3, 10, 25, 3, 60, 3, 40, 10);
    run_phase(24'd0, 24'd5, 24'd4, 24'd1, 24'd10, 6, 20, 25, 3, 80, 4, 45, 8);
    // Hammer one pair inside a huge window so the failure count saturates.
    run_phase(24'd255, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
              2, 32'h200_0000, 0, 0, 330, 1, 97, 0);
    run_phase(24'd255, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
              2, 32'h200_0000, 30, 3, 50, 2, 50, 4);
    run_phase(24'd2, 24'd20, 24'd8, 24'd3, 24'd50, 10, 80, 25, 3, 100, 4, 45, 8);
    run_phase(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
              32'h10_0000, 32'h300_0000, 30, 3, 60, 3, 45, 6);
    // First pause above the cap, so every doubling gets clipped.
    run_phase(24'd2, 24'd50, 24'h90_0000, 24'd7, 24'h30_0000,
              20, 32'h120_0000, 30, 2, 60, 2, 50, 3);

    hold_off(1);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Ran %0d items under %0d register settings, back to back and with idle gaps.",
             n_items, n_phases + 1);
    $display("Pairs paused or re-paused %0d times; %0d items admitted while half-open.",
             n_pauses, n_trials);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* link_circuit_breaker_table_unit.f */
rtl/core/lcbt_pkg.sv
rtl/core/lcbt_ram.sv
rtl/core/lcbt_ctrl.sv
rtl/core/lcbt_dpath.sv
rtl/core/link_circuit_breaker_table_unit.sv
sim/testbench.sv
